// ----- hw/rtl/ggd_pkg.sv -----
// Shared types, constants and helper functions for the glyph glow dilation block.
package ggd_pkg;

  localparam int MAX_GLYPH_W = 64;
  localparam int MAX_GLYPH_H = 64;
  localparam int BORDER      = 2;

  localparam int WIN        = 2 * BORDER + 1;
  localparam int STORE_ROWS = WIN;
  localparam int NUM_TAPS   = 12;

  localparam int PIX_W  = 8;
  localparam int DIM_W  = 7;
  localparam int WGT_W  = 8;
  localparam int EWGT_W = WGT_W + 1;
  localparam int WSHIFT = 8;
  localparam int PROD_W = PIX_W + EWGT_W;

  localparam int MAX_DIM = (MAX_GLYPH_W > MAX_GLYPH_H) ? MAX_GLYPH_W : MAX_GLYPH_H;
  localparam int CNT_W   = $clog2(MAX_DIM + 2 * BORDER + 1);
  localparam int ADDR_W  = $clog2(MAX_GLYPH_W);
  localparam int BANK_W  = $clog2(STORE_ROWS);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam int RST_GLYPH_W  = 16;
  localparam int RST_GLYPH_H  = 16;
  localparam int RST_OUTER_W  = 96;
  localparam int RST_INNER_W  = 255;
  localparam int RST_DIAG_W   = 160;
  localparam int WEIGHT_CAP   = 256;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [BANK_W-1:0] bank_t;
  typedef logic [WGT_W-1:0]  wgt_t;
  typedef logic [EWGT_W-1:0] ewgt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GLYPH_WIDTH     = 3'd0,
    REG_GLYPH_HEIGHT    = 3'd1,
    REG_OUTER_WEIGHT    = 3'd2,
    REG_INNER_WEIGHT    = 3'd3,
    REG_DIAGONAL_WEIGHT = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLS_OUTER = 2'd0,
    CLS_INNER = 2'd1,
    CLS_DIAG  = 2'd2
  } tap_cls_t;

  // Offsets of each tap back from the current grid position, and its weight class.
  localparam int TAP_OX [NUM_TAPS] = '{0, 4, 2, 2, 1, 3, 2, 2, 1, 1, 3, 3};
  localparam int TAP_OY [NUM_TAPS] = '{2, 2, 0, 4, 2, 2, 1, 3, 1, 3, 1, 3};
  localparam tap_cls_t TAP_CLS [NUM_TAPS] = '{
    CLS_OUTER, CLS_OUTER, CLS_OUTER, CLS_OUTER,
    CLS_INNER, CLS_INNER, CLS_INNER, CLS_INNER,
    CLS_DIAG,  CLS_DIAG,  CLS_DIAG,  CLS_DIAG
  };

  // Item held in the read stage while the line store data comes back.
  typedef struct packed {
    cnt_t  col;
    cnt_t  row;
    bank_t bank;
    pix_t  src;
    logic  wr;
    logic  last;
  } s1_ctrl_t;

  // Geometry and weights as the datapath sees them.
  typedef struct packed {
    cnt_t  gw;
    cnt_t  gh;
    ewgt_t w_outer;
    ewgt_t w_inner;
    ewgt_t w_diag;
  } cfg_view_t;

  function automatic ewgt_t eff_weight(input wgt_t w);
    ewgt_t sum;
    sum = ewgt_t'(w) + ewgt_t'(w >> 7);
    if (sum > ewgt_t'(WEIGHT_CAP)) begin
      sum = ewgt_t'(WEIGHT_CAP);
    end
    return sum;
  endfunction

  function automatic cnt_t clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
    cnt_t res;
    if (v == '0) begin
      res = cnt_t'(1);
    end else if (int'(v) > maxv) begin
      res = cnt_t'(maxv);
    end else begin
      res = cnt_t'(v);
    end
    return res;
  endfunction

  // Bank that holds the row k rows above the one in bank b.
  function automatic bank_t bank_back(input bank_t b, input int k);
    logic [BANK_W:0] s;
    s = (BANK_W + 1)'(b) + (BANK_W + 1)'(STORE_ROWS - k);
    if (s >= (BANK_W + 1)'(STORE_ROWS)) begin
      s = s - (BANK_W + 1)'(STORE_ROWS);
    end
    return s[BANK_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/ggd_line_store.sv -----
// Five line banks of glyph pixels, one per row modulo five, each with a registered read.
module ggd_line_store (
  input  logic           clk,
  input  logic           rd_en,
  input  logic           wr_en,
  input  ggd_pkg::bank_t wr_bank,
  input  logic [ggd_pkg::ADDR_W-1:0] addr,
  input  ggd_pkg::pix_t  wr_data,
  output ggd_pkg::pix_t  rd_data [ggd_pkg::STORE_ROWS]
);

  for (genvar b = 0; b < ggd_pkg::STORE_ROWS; b++) begin : g_bank
    ggd_pkg::pix_t bank_mem_r [ggd_pkg::MAX_GLYPH_W];
    ggd_pkg::pix_t rd_r;

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == ggd_pkg::bank_t'(b))) begin
        bank_mem_r[addr] <= wr_data;
      end
      if (rd_en) begin
        rd_r <= bank_mem_r[addr];
      end
    end

    assign rd_data[b] = rd_r;
  end

endmodule

// ----- hw/rtl/ggd_window.sv -----
// 5x5 window of raw store columns, position masks and the twelve weighted tap products.
module ggd_window (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  ggd_pkg::s1_ctrl_t  s1,
  input  ggd_pkg::pix_t      rd_data [ggd_pkg::STORE_ROWS],
  input  ggd_pkg::cfg_view_t cfg,
  output ggd_pkg::pix_t      taps [ggd_pkg::NUM_TAPS]
);

  localparam int WIN = ggd_pkg::WIN;

  ggd_pkg::pix_t colvec [WIN];
  ggd_pkg::pix_t win_r  [WIN-1][WIN];
  ggd_pkg::pix_t full   [WIN][WIN];
  ggd_pkg::pix_t taps_r [ggd_pkg::NUM_TAPS];
  logic [WIN-1:0] colok;
  logic [WIN-1:0] rowok;

  // The current row comes straight from the input when it is written in this transfer;
  // the bank read returned the old contents of that entry.
  always_comb begin
    colvec[0] = s1.wr ? s1.src : rd_data[s1.bank];
    for (int k = 1; k < WIN; k++) begin
      colvec[k] = rd_data[ggd_pkg::bank_back(s1.bank, k)];
    end
  end

  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      colok[k] = (int'(s1.col) >= k) && ((int'(s1.col) - k) < int'(cfg.gw));
      rowok[k] = (int'(s1.row) >= k) && ((int'(s1.row) - k) < int'(cfg.gh));
    end
  end

  always_comb begin
    for (int y = 0; y < WIN; y++) begin
      full[0][y] = colvec[y];
      for (int x = 1; x < WIN; x++) begin
        full[x][y] = win_r[x-1][y];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int x = 0; x < WIN - 1; x++) begin
        for (int y = 0; y < WIN; y++) begin
          win_r[x][y] <= '0;
        end
      end
    end else if (adv) begin
      win_r[0] <= colvec;
      for (int x = 1; x < WIN - 1; x++) begin
        win_r[x] <= win_r[x-1];
      end
    end
  end

  for (genvar i = 0; i < ggd_pkg::NUM_TAPS; i++) begin : g_tap
    localparam int OX = ggd_pkg::TAP_OX[i];
    localparam int OY = ggd_pkg::TAP_OY[i];
    ggd_pkg::pix_t  pix;
    ggd_pkg::ewgt_t wgt;
    logic [ggd_pkg::PROD_W-1:0] prod;

    if (ggd_pkg::TAP_CLS[i] == ggd_pkg::CLS_OUTER) begin : g_outer
      assign wgt = cfg.w_outer;
    end else if (ggd_pkg::TAP_CLS[i] == ggd_pkg::CLS_INNER) begin : g_inner
      assign wgt = cfg.w_inner;
    end else begin : g_diag
      assign wgt = cfg.w_diag;
    end

    assign pix  = (colok[OX] && rowok[OY]) ? full[OX][OY] : '0;
    assign prod = ggd_pkg::PROD_W'(pix) * ggd_pkg::PROD_W'(wgt);

    always_ff @(posedge clk) begin
      if (adv) begin
        taps_r[i] <= prod[ggd_pkg::WSHIFT +: ggd_pkg::PIX_W];
      end
    end
  end

  assign taps = taps_r;

endmodule

// ----- hw/rtl/ggd_max.sv -----
// Maximum over the twelve weighted taps, held in the output register.
module ggd_max (
  input  logic          clk,
  input  logic          load,
  input  ggd_pkg::pix_t taps [ggd_pkg::NUM_TAPS],
  input  logic          last_in,
  output ggd_pkg::pix_t glow,
  output logic          last
);

  ggd_pkg::pix_t lvl1 [6];
  ggd_pkg::pix_t lvl2 [3];
  ggd_pkg::pix_t lvl3;
  ggd_pkg::pix_t best;
  ggd_pkg::pix_t glow_r;
  logic          last_r;

  function automatic ggd_pkg::pix_t max2(input ggd_pkg::pix_t a, input ggd_pkg::pix_t b);
    return (a > b) ? a : b;
  endfunction

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      lvl1[i] = max2(taps[2*i], taps[2*i+1]);
    end
    for (int i = 0; i < 3; i++) begin
      lvl2[i] = max2(lvl1[2*i], lvl1[2*i+1]);
    end
    lvl3 = max2(lvl2[0], lvl2[1]);
    best = max2(lvl3, lvl2[2]);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      glow_r <= best;
      last_r <= last_in;
    end
  end

  assign glow = glow_r;
  assign last = last_r;

endmodule

// ----- hw/rtl/glyph_glow_dilation.sv -----
// Top level of the glyph glow dilation block: configuration, raster counters and pipeline control.
//
// Source pixels arrive on the in_ channel in raster order over the glyph grid grown by two
// pixels on every side; one glow pixel leaves on the out_ channel for each, in the same order,
// with out_last_pixel marking the final position of the grown grid.
// Configuration is to be written through cfg_we, cfg_index and cfg_wdata only while no item is
// in flight; the user must keep to this, as the block does not enforce it. A result passes the
// read stage, tap stage and output register before out_valid shows it. Throughput: one pixel
// per cycle when not stalled. Each of the five line banks gives one read and one write per cycle,
// all banks are read at the current column and only the current row's bank is written.
// Reset restores the default geometry and weights, zeroes the raster counters and the window,
// and empties the pipeline. The line banks are not cleared; reads are masked by position.
// When the receiver stalls, the output register holds its result and the two stages before
// it keep taking transfers until they are full; in_stall rises only then.
module glyph_glow_dilation (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ggd_pkg::PIX_W-1:0]          in_src_pixel,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ggd_pkg::PIX_W-1:0]          out_glow_pixel,
  output logic                               out_last_pixel,
  input  logic                               cfg_we,
  input  logic [ggd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ggd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CNT_W = ggd_pkg::CNT_W;

  logic [ggd_pkg::DIM_W-1:0] glyph_width_r;
  logic [ggd_pkg::DIM_W-1:0] glyph_height_r;
  ggd_pkg::wgt_t             outer_weight_r;
  ggd_pkg::wgt_t             inner_weight_r;
  ggd_pkg::wgt_t             diagonal_weight_r;

  ggd_pkg::cnt_t  col_r, col_nxt;
  ggd_pkg::cnt_t  row_r, row_nxt;
  ggd_pkg::bank_t bank_r, bank_nxt;
  logic           s1_v_r, s1_v_nxt;
  logic           s2_v_r, s2_v_nxt;
  logic           out_valid_r, out_valid_nxt;
  ggd_pkg::s1_ctrl_t s1_r;
  logic           s2_last_r;

  ggd_pkg::cfg_view_t cfg_view;
  ggd_pkg::cnt_t  ew, eh;
  logic [CNT_W:0] col_inc, row_inc;
  logic           col_end, row_end, wr_here;
  logic           in_acc, out_en, s2_mv, adv1;

  ggd_pkg::pix_t  rd_data [ggd_pkg::STORE_ROWS];
  ggd_pkg::pix_t  taps    [ggd_pkg::NUM_TAPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_width_r     <= ggd_pkg::DIM_W'(ggd_pkg::RST_GLYPH_W);
      glyph_height_r    <= ggd_pkg::DIM_W'(ggd_pkg::RST_GLYPH_H);
      outer_weight_r    <= ggd_pkg::WGT_W'(ggd_pkg::RST_OUTER_W);
      inner_weight_r    <= ggd_pkg::WGT_W'(ggd_pkg::RST_INNER_W);
      diagonal_weight_r <= ggd_pkg::WGT_W'(ggd_pkg::RST_DIAG_W);
    end else if (cfg_we) begin
      unique case (ggd_pkg::cfg_reg_t'(cfg_index))
        ggd_pkg::REG_GLYPH_WIDTH:     glyph_width_r     <= cfg_wdata[ggd_pkg::DIM_W-1:0];
        ggd_pkg::REG_GLYPH_HEIGHT:    glyph_height_r    <= cfg_wdata[ggd_pkg::DIM_W-1:0];
        ggd_pkg::REG_OUTER_WEIGHT:    outer_weight_r    <= cfg_wdata[ggd_pkg::WGT_W-1:0];
        ggd_pkg::REG_INNER_WEIGHT:    inner_weight_r    <= cfg_wdata[ggd_pkg::WGT_W-1:0];
        ggd_pkg::REG_DIAGONAL_WEIGHT: diagonal_weight_r <= cfg_wdata[ggd_pkg::WGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_view.gw      = ggd_pkg::clamp_dim(glyph_width_r, ggd_pkg::MAX_GLYPH_W);
    cfg_view.gh      = ggd_pkg::clamp_dim(glyph_height_r, ggd_pkg::MAX_GLYPH_H);
    cfg_view.w_outer = ggd_pkg::eff_weight(outer_weight_r);
    cfg_view.w_inner = ggd_pkg::eff_weight(inner_weight_r);
    cfg_view.w_diag  = ggd_pkg::eff_weight(diagonal_weight_r);
  end

  assign ew      = cfg_view.gw + CNT_W'(2 * ggd_pkg::BORDER);
  assign eh      = cfg_view.gh + CNT_W'(2 * ggd_pkg::BORDER);
  assign col_inc = (CNT_W + 1)'(col_r) + (CNT_W + 1)'(1);
  assign row_inc = (CNT_W + 1)'(row_r) + (CNT_W + 1)'(1);
  // A count left past the end by a geometry change also wraps here.
  assign col_end = col_inc >= (CNT_W + 1)'(ew);
  assign row_end = row_inc >= (CNT_W + 1)'(eh);
  assign wr_here = (col_r < cfg_view.gw) && (row_r < cfg_view.gh);

  // Pipeline control: each stage moves on when the next one is empty or moving.
  assign out_en   = !out_valid_r || !out_stall;
  assign s2_mv    = s2_v_r && out_en;
  assign adv1     = s1_v_r && (!s2_v_r || s2_mv);
  assign in_stall = s1_v_r && !adv1;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    bank_nxt = bank_r;
    if (in_acc) begin
      if (col_end) begin
        col_nxt = '0;
        if (row_end) begin
          row_nxt  = '0;
          bank_nxt = '0;
        end else begin
          row_nxt  = row_inc[CNT_W-1:0];
          bank_nxt = (bank_r == ggd_pkg::bank_t'(ggd_pkg::STORE_ROWS - 1)) ? '0
                     : bank_r + ggd_pkg::bank_t'(1);
        end
      end else begin
        col_nxt = col_inc[CNT_W-1:0];
      end
    end
    s1_v_nxt      = in_acc ? 1'b1 : (adv1 ? 1'b0 : s1_v_r);
    s2_v_nxt      = adv1 ? 1'b1 : (s2_mv ? 1'b0 : s2_v_r);
    out_valid_nxt = s2_mv ? 1'b1 : (out_en ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      bank_r      <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      bank_r      <= bank_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.col  <= col_r;
      s1_r.row  <= row_r;
      s1_r.bank <= bank_r;
      s1_r.src  <= in_src_pixel;
      s1_r.wr   <= wr_here;
      s1_r.last <= col_end && row_end;
    end
    if (adv1) begin
      s2_last_r <= s1_r.last;
    end
  end

  ggd_line_store u_store (
    .clk     (clk),
    .rd_en   (in_acc),
    .wr_en   (in_acc && wr_here),
    .wr_bank (bank_r),
    .addr    (col_r[ggd_pkg::ADDR_W-1:0]),
    .wr_data (in_src_pixel),
    .rd_data (rd_data)
  );

  ggd_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv1),
    .s1      (s1_r),
    .rd_data (rd_data),
    .cfg     (cfg_view),
    .taps    (taps)
  );

  ggd_max u_max (
    .clk     (clk),
    .load    (s2_mv),
    .taps    (taps),
    .last_in (s2_last_r),
    .glow    (out_glow_pixel),
    .last    (out_last_pixel)
  );

  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/ggd_checker.sv -----
// Port-level checks for the glyph glow dilation block, bound to its top level.
module ggd_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [ggd_pkg::PIX_W-1:0]      in_src_pixel,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [ggd_pkg::PIX_W-1:0]      out_glow_pixel,
  input  logic                           out_last_pixel,
  input  logic                           cfg_we,
  input  logic [ggd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ggd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic       in_xfer, out_xfer;
  logic [2:0] inflight_r, inflight_nxt;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_xfer && !out_xfer) begin
      inflight_nxt = inflight_r + 3'd1;
    end else if (!in_xfer && out_xfer) begin
      inflight_nxt = inflight_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  // A result that is held back keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_glow_pixel)
                               && $stable(out_last_pixel))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  // No result is offered without an input transfer still owed one.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 3'd0)
    else $error("result without a pending input");

  // Three stages at most hold items.
  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 3'd3)
    else $error("more items in flight than the pipeline holds");

  // In a cycle in which the receiver does not stall, the input is not stalled either.
  a_full_rate: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while the output drains freely");

endmodule

bind glyph_glow_dilation ggd_checker u_ggd_checker (.*);

// ----- verif/tb_top.sv -----
// Self-checking testbench for glyph_glow_dilation with its own raster and glow predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ggd_pkg::*;

  typedef struct {
    pix_t glow;
    logic last;
  } glow_result_t;

  typedef enum int {FILL_RANDOM, FILL_SPARSE, FILL_EXTREME, FILL_SATURATED} fill_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  pix_t                  in_src_pixel;
  logic                  out_valid;
  logic                  out_stall;
  pix_t                  out_glow_pixel;
  logic                  out_last_pixel;
  logic                  cfg_we;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Predictor copy of the configuration, the line store and the raster position.
  logic [DIM_W-1:0] reg_width;
  logic [DIM_W-1:0] reg_height;
  wgt_t             wgt_outer;
  wgt_t             wgt_inner;
  wgt_t             wgt_diag;
  pix_t             glyph_rows [STORE_ROWS][MAX_GLYPH_W];
  bit               row_written [STORE_ROWS][MAX_GLYPH_W];
  int               col_pos;
  int               row_pos;

  glow_result_t glow_expected [$];

  int send_idle_pct;
  int recv_stall_pct;
  int error_count;
  int pixels_sent;
  int results_checked;
  int frames_done;
  int cfg_writes;
  int midframe_changes;

  glyph_glow_dilation uut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int fit_dim(logic [DIM_W-1:0] v, int top);
    if (v == '0) return 1;
    return (int'(v) > top) ? top : int'(v);
  endfunction

  function automatic int scaled_weight(wgt_t w);
    int s;
    s = int'(w) + int'(w[WGT_W-1]);
    return (s > 256) ? 256 : s;
  endfunction

  // Weight of the tap at offset (dx,dy) from the centre; zero where no tap exists.
  function automatic int tap_weight(int dx, int dy);
    int ax;
    int ay;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax + ay == 1) return scaled_weight(wgt_inner);
    if (ax == 1 && ay == 1) return scaled_weight(wgt_diag);
    if (ax + ay == 2 && (ax == 0 || ay == 0)) return scaled_weight(wgt_outer);
    return 0;
  endfunction

  function automatic glow_result_t predict_glow(pix_t src);
    int gw;
    int gh;
    int ew;
    int eh;
    int ox;
    int oy;
    int x;
    int y;
    int wt;
    int prod;
    int best;
    glow_result_t res;
    gw = fit_dim(reg_width, MAX_GLYPH_W);
    gh = fit_dim(reg_height, MAX_GLYPH_H);
    ew = gw + 2 * BORDER;
    eh = gh + 2 * BORDER;
    if (col_pos < gw && row_pos < gh) begin
      glyph_rows[row_pos % STORE_ROWS][col_pos] = src;
      row_written[row_pos % STORE_ROWS][col_pos] = 1'b1;
    end
    best = 0;
    for (oy = 0; oy < 2 * BORDER + 1; oy++) begin
      for (ox = 0; ox < 2 * BORDER + 1; ox++) begin
        wt = tap_weight(ox - BORDER, oy - BORDER);
        x = col_pos - ox;
        y = row_pos - oy;
        if (wt != 0 && x >= 0 && y >= 0 && x < gw && y < gh) begin
          prod = (int'(glyph_rows[y % STORE_ROWS][x]) * wt) >> 8;
          if (prod > best) best = prod;
        end
      end
    end
    res.glow = best[PIX_W-1:0];
    res.last = (col_pos + 1 >= ew && row_pos + 1 >= eh);
    if (col_pos + 1 >= ew) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= eh) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return res;
  endfunction

  function automatic int items_to_frame_end();
    int ew;
    int eh;
    int in_row;
    int rows_after;
    ew = fit_dim(reg_width, MAX_GLYPH_W) + 2 * BORDER;
    eh = fit_dim(reg_height, MAX_GLYPH_H) + 2 * BORDER;
    in_row = (col_pos + 1 >= ew) ? 1 : ew - col_pos;
    rows_after = (row_pos + 1 >= eh) ? 0 : eh - 1 - row_pos;
    return in_row + rows_after * ew;
  endfunction

  // A geometry change in mid-frame may only expose store entries that already hold a pixel.
  function automatic bit stale_safe(logic [7:0] w, logic [7:0] h);
    int gw;
    int gh;
    int b;
    int x;
    gw = fit_dim(w[DIM_W-1:0], MAX_GLYPH_W);
    gh = fit_dim(h[DIM_W-1:0], MAX_GLYPH_H);
    for (b = 0; b < STORE_ROWS && b < gh; b++) begin
      for (x = 0; x < gw; x++) begin
        if (!row_written[b][x]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic pix_t pick_pixel(fill_t mode);
    case (mode)
      FILL_SPARSE:    return ($urandom_range(7) == 0) ? pix_t'($urandom_range(1, 255)) : '0;
      FILL_SATURATED: return 8'hFF;
      FILL_EXTREME: begin
        case ($urandom_range(3))
          0:       return 8'h00;
          1:       return 8'hFF;
          2:       return 8'h7F;
          default: return 8'h80;
        endcase
      end
      default:        return pix_t'($urandom_range(255));
    endcase
  endfunction

  function automatic wgt_t pick_weight();
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0:       return 8'd0;
        1:       return 8'd127;
        2:       return 8'd128;
        default: return 8'd255;
      endcase
    end
    return wgt_t'($urandom_range(255));
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (error_count < 40) begin
      $display("Mismatch at %0t ns: %s got %0d, expected %0d", $time, what, got, want);
    end
    error_count++;
  endtask

  // Every result transfer is compared with the oldest outstanding prediction.
  always @(posedge clk) begin : check_results
    glow_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (glow_expected.size() == 0) begin
        report_mismatch("result with no prediction pending, glow_pixel", out_glow_pixel, -1);
      end else begin
        want = glow_expected.pop_front();
        results_checked++;
        if (out_glow_pixel !== want.glow) begin
          report_mismatch("glow_pixel", out_glow_pixel, want.glow);
        end
        if (out_last_pixel !== want.last) begin
          report_mismatch("last_pixel", out_last_pixel, want.last);
        end
        if (want.last) frames_done++;
      end
    end
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_stall_pct);
  end

  task automatic set_idling(int send_pct, int stall_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_pixel(pix_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_src_pixel = px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    glow_expected.push_back(predict_glow(px));
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic send_items(int n, fill_t mode);
    repeat (n) send_pixel(pick_pixel(mode));
  endtask

  task automatic send_frame(fill_t mode);
    send_items(items_to_frame_end(), mode);
  endtask

  // Hold the input back until every predicted result has been seen and the pipeline is empty.
  task automatic settle();
    in_valid = 1'b0;
    while (glow_expected.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [7:0] val);
    settle();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_GLYPH_WIDTH:     reg_width = val[DIM_W-1:0];
      REG_GLYPH_HEIGHT:    reg_height = val[DIM_W-1:0];
      REG_OUTER_WEIGHT:    wgt_outer = val;
      REG_INNER_WEIGHT:    wgt_inner = val;
      REG_DIAGONAL_WEIGHT: wgt_diag = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_geometry(logic [7:0] w, logic [7:0] h);
    write_reg(REG_GLYPH_WIDTH, w);
    write_reg(REG_GLYPH_HEIGHT, h);
  endtask

  task automatic set_weights(wgt_t o, wgt_t i, wgt_t d);
    write_reg(REG_OUTER_WEIGHT, o);
    write_reg(REG_INNER_WEIGHT, i);
    write_reg(REG_DIAGONAL_WEIGHT, d);
  endtask

  task automatic random_setup();
    int pick;
    logic [7:0] w;
    logic [7:0] h;
    pick = $urandom_range(99);
    if (pick < 85) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(0, 6);
    end else if (pick < 95) begin
      w = $urandom_range(9, 20);
      h = $urandom_range(4, 12);
    end else begin
      // Any width code, including ones beyond the limit, on a flat glyph.
      w = $urandom_range(255);
      h = $urandom_range(2);
    end
    set_geometry(w, h);
    set_weights(pick_weight(), pick_weight(), pick_weight());
  endtask

  task automatic test_reset_defaults();
    send_frame(FILL_RANDOM);
  endtask

  task automatic test_tap_weights();
    // A single lit pixel shows each tap class with its own weight.
    set_geometry(8'd1, 8'd1);
    set_weights(8'd40, 8'd120, 8'd200);
    send_pixel(8'hFF);
    send_frame(FILL_RANDOM);
    set_geometry(8'd3, 8'd2);
    set_weights(8'd255, 8'd255, 8'd255);
    send_frame(FILL_EXTREME);
    set_weights(8'd0, 8'd0, 8'd0);
    send_frame(FILL_EXTREME);
    set_weights(8'd128, 8'd127, 8'd1);
    send_frame(FILL_EXTREME);
    set_weights(8'd0, 8'd255, 8'd0);
    send_frame(FILL_SATURATED);
  endtask

  task automatic test_geometry_limits();
    set_geometry(8'd0, 8'd0);
    send_frame(FILL_RANDOM);
    // The top bit of the data is dropped, so these read as 127 and 0.
    set_geometry(8'hFF, 8'h80);
    send_frame(FILL_SPARSE);
    set_geometry(8'd2, 8'd65);
    send_frame(FILL_RANDOM);
  endtask

  task automatic test_frame_wrap();
    set_geometry(8'd4, 8'd3);
    set_weights(pick_weight(), pick_weight(), pick_weight());
    repeat (3) send_frame(FILL_RANDOM);
  endtask

  task automatic test_midframe_geometry();
    set_geometry(8'd10, 8'd6);
    set_weights(8'd96, 8'd255, 8'd160);
    send_frame(FILL_RANDOM);
    // Column 12 of row 2 lies past the last column of the narrower grid.
    send_items(40, FILL_RANDOM);
    set_geometry(8'd6, 8'd6);
    midframe_changes++;
    send_items(25, FILL_RANDOM);
    set_geometry(8'd6, 8'd2);
    midframe_changes++;
    send_frame(FILL_RANDOM);
    // Both counts end up past the end of the smaller grid.
    set_geometry(8'd10, 8'd6);
    send_items(124, FILL_RANDOM);
    set_geometry(8'd3, 8'd3);
    midframe_changes++;
    send_frame(FILL_RANDOM);
    send_items(20, FILL_RANDOM);
    set_geometry(8'd10, 8'd6);
    midframe_changes++;
    send_frame(FILL_RANDOM);
  endtask

  task automatic test_random_traffic(int target);
    int sent;
    fill_t mode;
    logic [7:0] w;
    logic [7:0] h;
    sent = 0;
    mode = FILL_RANDOM;
    while (sent < target) begin
      if (col_pos == 0 && row_pos == 0) begin
        mode = ($urandom_range(1) == 1) ? FILL_RANDOM : fill_t'($urandom_range(3));
        if ($urandom_range(99) < 40) random_setup();
      end else if ($urandom_range(99) == 0) begin
        w = $urandom_range(1, 10);
        h = $urandom_range(1, 8);
        if (stale_safe(w, h)) begin
          set_geometry(w, h);
          midframe_changes++;
        end
      end else if ($urandom_range(99) < 2) begin
        settle();
      end
      send_pixel(pick_pixel(mode));
      sent++;
    end
    settle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_src_pixel = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_GLYPH_WIDTH;
    cfg_wdata = '0;
    reg_width = RST_GLYPH_W;
    reg_height = RST_GLYPH_H;
    wgt_outer = RST_OUTER_W;
    wgt_inner = RST_INNER_W;
    wgt_diag = RST_DIAG_W;
    col_pos = 0;
    row_pos = 0;
    error_count = 0;
    pixels_sent = 0;
    results_checked = 0;
    frames_done = 0;
    cfg_writes = 0;
    midframe_changes = 0;
    set_idling(36, 72);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_tap_weights();
    test_geometry_limits();
    test_frame_wrap();
    test_midframe_geometry();
    test_random_traffic(233);
    set_idling(72, 36);
    test_random_traffic(233);
    set_idling(0, 0);
    test_random_traffic(234);

    settle();
    repeat (8) @(negedge clk);
    $display("Run covered %0d pixel transfers and %0d checked results over %0d whole frames.",
             pixels_sent, results_checked, frames_done);
    $display("It made %0d register writes, %0d of them geometry changes in mid-frame.",
             cfg_writes, midframe_changes);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ggd_pkg.sv
hw/rtl/ggd_line_store.sv
hw/rtl/ggd_window.sv
hw/rtl/ggd_max.sv
hw/rtl/glyph_glow_dilation.sv
hw/rtl/ggd_checker.sv
verif/tb_top.sv
